### sv/pulse_period_flow_meter_assert.svh
// Assertion macros used by the flow meter top level.
`ifndef PULSE_PERIOD_FLOW_METER_ASSERT_SVH
`define PULSE_PERIOD_FLOW_METER_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define PPFM_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define PPFM_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ppfm_pkg.sv
// Package: widths, codes, state type and divider status for the flow meter.
`timescale 1ns / 1ps
package ppfm_pkg;

  localparam int DATA_W     = 32;
  localparam int WINDOW_DEF = 16;
  localparam int DIV_STEPS  = DATA_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0] CF_RESET = DATA_W'(1);
  localparam logic [DATA_W-1:0] RATE_SAT = {DATA_W{1'b1}};

  localparam logic MODE_PULSE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_OLD,
    ST_SPAN,
    ST_DIV_MEAN,
    ST_MEAN_FIX,
    ST_DIV_RATE,
    ST_DONE
  } ppfm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### sv/ppfm_if.sv
// Channel interfaces: pulse/query input, result output, configuration write.
`timescale 1ns / 1ps
interface ppfm_in_if import ppfm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [DATA_W-1:0] pulse_time;

  modport source (output valid, mode, pulse_time, input ready);
  modport sink   (input valid, mode, pulse_time, output ready);
endinterface

interface ppfm_out_if import ppfm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ready_res;
  logic [DATA_W-1:0] mean_interval;
  logic [DATA_W-1:0] flow_rate;

  modport source (output valid, ready_res, mean_interval, flow_rate, input ready);
  modport sink   (input valid, ready_res, mean_interval, flow_rate, output ready);
endinterface

interface ppfm_cfg_if import ppfm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] conversion_factor;

  modport source (output valid, conversion_factor, input ready);
  modport sink   (input valid, conversion_factor, output ready);
endinterface

### sv/ppfm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module ppfm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/ppfm_div.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ppfm_div import ppfm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic [DATA_W-1:0] quotient,
  output div_stat_t         stat
);

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W:0]   trial;

  // Shift in the next dividend bit and try the subtract.
  assign trial = {rem_r, quo_r[DATA_W-1]} - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DATA_W]) begin
        rem_nxt = trial[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### sv/pulse_period_flow_meter.sv
// Top level of the pulse-period flow meter: timestamp ring, query sequencer, result register.
// After a pulse transfer the sequencer stays idle, so the next item can be taken in the following cycle.
// A not-ready query goes from idle straight to ST_DONE, which loads the result register; a zero-mean
// query first passes ST_RD_OLD, ST_SPAN, ST_DIV_MEAN and ST_MEAN_FIX, a ready query also a 32-step divide.
// Output stalls hold the sequencer in ST_DONE; the next item can be taken in the cycle after the result load.
// Sync active-low reset clears pointers, count, full flag, output valid; factor resets to 1.
`timescale 1ns / 1ps
`include "pulse_period_flow_meter_assert.svh"
module pulse_period_flow_meter import ppfm_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ppfm_in_if.sink     in_chan,
  ppfm_out_if.source  out_chan,
  ppfm_cfg_if.sink    cfg_chan
);

  // Ring holds WINDOW+1 stamps: the newest and the one WINDOW pulses back.
  localparam int DEPTH  = WINDOW + 1;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW);
  localparam logic [SLOT_W-1:0] FULL_CNT  = SLOT_W'(WINDOW);

  // Division of the span by WINDOW as a reciprocal multiply:
  // mean = (t1 + ((span - t1) >> 1)) >> (MEAN_SH - 1), t1 = high word of span * MEAN_MUL.
  localparam int MEAN_SH = $clog2(WINDOW);
  localparam logic [63:0] MEAN_MUL_W =
    (((64'd1 << MEAN_SH) - 64'(WINDOW)) << DATA_W) / 64'(WINDOW) + 64'd1;
  localparam logic [DATA_W-1:0] MEAN_MUL = DATA_W'(MEAN_MUL_W);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
  endfunction

  ppfm_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] newest_r, newest_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic              full_r, full_nxt;
  logic [DATA_W-1:0] cf_r;
  logic [DATA_W-1:0] stamp_r, stamp_nxt;
  logic [DATA_W-1:0] span_r, span_nxt;
  logic [DATA_W-1:0] t1_r, t1_nxt;
  logic              res_ready_r, res_ready_nxt;
  logic [DATA_W-1:0] mean_r, mean_nxt;
  logic [DATA_W-1:0] rate_r, rate_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_rdy_res_r, out_rdy_res_nxt;
  logic [DATA_W-1:0] out_mean_r, out_mean_nxt;
  logic [DATA_W-1:0] out_rate_r, out_rate_nxt;

  logic              in_ready;
  logic              in_xfer;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [SLOT_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic [DATA_W-1:0] mean_hi;
  logic [DATA_W-1:0] mean_q;

  logic              div_start;
  logic [DATA_W-1:0] div_dividend;
  logic [DATA_W-1:0] div_divisor;
  logic [DATA_W-1:0] div_quo;
  div_stat_t         div_stat;

  logic              out_not_ready;
  logic              out_zero_fields;
  logic              out_zero_mean;
  logic              early_query;

  // Timestamp ring storage.
  ppfm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_chan.pulse_time),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Bit-serial divider for factor / mean; the mean itself uses the reciprocal multiply.
  ppfm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign in_ready      = (state_r == ST_IDLE);
  assign in_chan.ready = in_ready;
  assign in_xfer       = in_chan.valid && in_ready;

  // The register port never stalls; writes must arrive only while idle, which the block does not enforce.
  assign cfg_chan.ready = 1'b1;

  // Read the newest slot while idle so a query finds it waiting; then the oldest.
  assign ram_raddr = (state_r == ST_RD_OLD) ? oldest_r : newest_r;
  assign ram_waddr = next_slot(newest_r);

  // High word of span times the reciprocal, then the correction step.
  assign mean_hi = DATA_W'((64'(span_r) * 64'(MEAN_MUL)) >> DATA_W);
  assign mean_q  = (t1_r + ((span_r - t1_r) >> 1)) >> (MEAN_SH - 1);

  always_comb begin
    state_nxt       = state_r;
    newest_nxt      = newest_r;
    oldest_nxt      = oldest_r;
    cnt_nxt         = cnt_r;
    full_nxt        = full_r;
    stamp_nxt       = stamp_r;
    span_nxt        = span_r;
    t1_nxt          = t1_r;
    res_ready_nxt   = res_ready_r;
    mean_nxt        = mean_r;
    rate_nxt        = rate_r;
    out_valid_nxt   = out_valid_r;
    out_rdy_res_nxt = out_rdy_res_r;
    out_mean_nxt    = out_mean_r;
    out_rate_nxt    = out_rate_r;
    ram_we          = 1'b0;
    div_start       = 1'b0;
    div_dividend    = '0;
    div_divisor     = '0;

    // Drop the held result once the sink takes it.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_chan.mode == MODE_PULSE) begin
            // Store the stamp in the slot after the newest and advance both pointers.
            ram_we     = 1'b1;
            newest_nxt = ram_waddr;
            oldest_nxt = next_slot(ram_waddr);
            if (cnt_r != FULL_CNT) begin
              cnt_nxt = cnt_r + SLOT_W'(1);
            end else begin
              full_nxt = 1'b1;
            end
          end else if (!full_r) begin
            // Not enough pulses yet: report all zeros.
            res_ready_nxt = 1'b0;
            mean_nxt      = '0;
            rate_nxt      = '0;
            state_nxt     = ST_DONE;
          end else begin
            state_nxt = ST_RD_OLD;
          end
        end
      end
      ST_RD_OLD: begin
        // Capture the newest stamp; the oldest read is in flight.
        stamp_nxt = ram_rdata;
        state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        // Span wraps modulo 2^32; hold it for the mean.
        span_nxt  = stamp_r - ram_rdata;
        state_nxt = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        // Hold the high word of the reciprocal product.
        t1_nxt    = mean_hi;
        state_nxt = ST_MEAN_FIX;
      end
      ST_MEAN_FIX: begin
        res_ready_nxt = 1'b1;
        mean_nxt      = mean_q;
        if (mean_q == '0) begin
          // Zero mean interval saturates the rate.
          rate_nxt  = RATE_SAT;
          state_nxt = ST_DONE;
        end else begin
          div_start    = 1'b1;
          div_dividend = cf_r;
          div_divisor  = mean_q;
          state_nxt    = ST_DIV_RATE;
        end
      end
      ST_DIV_RATE: begin
        if (div_stat.done) begin
          rate_nxt  = div_quo;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Load the output register once it is free or being emptied.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt   = 1'b1;
          out_rdy_res_nxt = res_ready_r;
          out_mean_nxt    = mean_r;
          out_rate_nxt    = rate_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      newest_r    <= '0;
      oldest_r    <= '0;
      cnt_r       <= '0;
      full_r      <= 1'b0;
      cf_r        <= CF_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      cnt_r       <= cnt_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        cf_r <= cfg_chan.conversion_factor;
      end
    end
    stamp_r       <= stamp_nxt;
    span_r        <= span_nxt;
    t1_r          <= t1_nxt;
    res_ready_r   <= res_ready_nxt;
    mean_r        <= mean_nxt;
    rate_r        <= rate_nxt;
    out_rdy_res_r <= out_rdy_res_nxt;
    out_mean_r    <= out_mean_nxt;
    out_rate_r    <= out_rate_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.ready_res     = out_rdy_res_r;
  assign out_chan.mean_interval = out_mean_r;
  assign out_chan.flow_rate     = out_rate_r;

  assign out_not_ready   = out_valid_r && !out_rdy_res_r;
  assign out_zero_fields = (out_mean_r == '0) && (out_rate_r == '0);
  assign out_zero_mean   = out_valid_r && out_rdy_res_r && (out_mean_r == '0);
  assign early_query     = in_xfer && (in_chan.mode == MODE_QUERY) && !full_r;

  `PPFM_ASSERT_IMP(a_full_needs_count, clk, rst_n, full_r, cnt_r == FULL_CNT, "full too early")
  `PPFM_ASSERT_IMP(a_old_next, clk, rst_n, cnt_r != '0, oldest_r == next_slot(newest_r), "oldest")
  `PPFM_ASSERT_IMP(a_div_done, clk, rst_n, div_stat.done, state_r == ST_DIV_RATE, "stray divide")
  `PPFM_ASSERT_IMP(a_not_ready_zero, clk, rst_n, out_not_ready, out_zero_fields, "nonzero fields")
  `PPFM_ASSERT_IMP(a_zero_mean_sat, clk, rst_n, out_zero_mean, out_rate_r == RATE_SAT, "no saturation")
  `PPFM_ASSERT_NXT(a_early_query, clk, rst_n, early_query, state_r == ST_DONE && !res_ready_r, "early")

endmodule
